// ----- src/tesp_pkg.sv -----
// ----------------------------------------------------------------------------
// tesp_pkg
// shared types, codes and limits of the escape-sequence parser
// ----------------------------------------------------------------------------
package tesp_pkg;

    localparam int CODE_W      = 21;
    localparam int KIND_W      = 3;
    localparam int INTER_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int INDEX_W     = 6;
    localparam int PVAL_W      = 17;
    localparam int OCHAR_W     = 7;
    localparam int OSC_ADDR_W  = 6;
    localparam int PAR_ADDR_W  = 5;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int OSC_MAX_DEF    = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [PVAL_W-1:0] PARAM_LIMIT = PVAL_W'(9999);

    // event kinds
    localparam logic [KIND_W-1:0] EV_CONTROL = 3'd0;
    localparam logic [KIND_W-1:0] EV_ESCAPE  = 3'd1;
    localparam logic [KIND_W-1:0] EV_CSI     = 3'd2;
    localparam logic [KIND_W-1:0] EV_PRINT   = 3'd3;
    localparam logic [KIND_W-1:0] EV_OSC     = 3'd4;

    // character codes
    localparam logic [CODE_W-1:0] CH_NUL  = 21'h00;
    localparam logic [CODE_W-1:0] CH_BEL  = 21'h07;
    localparam logic [CODE_W-1:0] CH_CAN  = 21'h18;
    localparam logic [CODE_W-1:0] CH_SUB  = 21'h1a;
    localparam logic [CODE_W-1:0] CH_ESC  = 21'h1b;
    localparam logic [CODE_W-1:0] CH_ZERO = 21'h30;
    localparam logic [CODE_W-1:0] CH_COL  = 21'h3a;
    localparam logic [CODE_W-1:0] CH_SEMI = 21'h3b;
    localparam logic [CODE_W-1:0] CH_CSI  = 21'h5b;
    localparam logic [CODE_W-1:0] CH_OSC  = 21'h5d;
    localparam logic [CODE_W-1:0] CH_DEL  = 21'h7f;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [INTER_W-1:0] inter;
        logic [COUNT_W-1:0] count;
    } event_t;

    typedef struct packed {
        logic                  osc_we;
        logic [OSC_ADDR_W-1:0] osc_addr;
        logic [OCHAR_W-1:0]    osc_data;
        logic                  par_we;
        logic [PAR_ADDR_W-1:0] par_addr;
        logic [PVAL_W-1:0]     par_data;
    } store_wr_t;

endpackage

// ----- src/terminal_escape_sequence_parser_core.sv -----
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser_core
// escape-sequence parser: characters in, control/escape/print/csi/osc events out
// ----------------------------------------------------------------------------
//  channel | ports                 | direction | carries
//  --------+-----------------------+-----------+-------------------------------
//  input   | s_valid/s_ready/s_*   | in        | one character code
//  result  | m_valid/m_ready/m_*   | out       | one result of an event
//
//  a character is parsed in the cycle it is accepted; events go to a
//  two-entry queue, so the input keeps flowing until the queue fills
//  the sequencer picks up an event in B_IDLE, then for each result reads
//  the store (B_READ) and then drives the output (B_OUT), where a result
//  waits for as long as m_ready stays low
//  the input stalls from a csi/osc dispatch until its last result is taken,
//  since the sequencer reads the collected stores
//  aresetn is synchronous, active low; stores hold no reset value
// ----------------------------------------------------------------------------
module terminal_escape_sequence_parser_core #(
    parameter int MAX_PARAMS = tesp_pkg::MAX_PARAMS_DEF,
    parameter int OSC_MAX    = tesp_pkg::OSC_MAX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tesp_pkg::CODE_W-1:0]  s_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tesp_pkg::KIND_W-1:0]  m_event_kind,
    output logic [tesp_pkg::CODE_W-1:0]  m_final_code,
    output logic [tesp_pkg::INTER_W-1:0] m_intermediate,
    output logic [tesp_pkg::COUNT_W-1:0] m_item_count,
    output logic [tesp_pkg::INDEX_W-1:0] m_item_index,
    output logic [tesp_pkg::PVAL_W-1:0]  m_param_value,
    output logic [tesp_pkg::OCHAR_W-1:0] m_osc_char,
    output logic                         m_last
);
    import tesp_pkg::*;

    // front to queue
    logic        q_push, q_ready;
    event_t      q_event;
    // queue to back
    logic        head_valid, pop;
    event_t      head_event;
    // store traffic and dispatch release
    store_wr_t   store_wr;
    logic [PVAL_W-1:0] cur_param;
    logic        multi_done;

    tesp_front #(
        .MAX_PARAMS (MAX_PARAMS),
        .OSC_MAX    (OSC_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_code     (s_code),
        .q_push     (q_push),
        .q_ready    (q_ready),
        .q_event    (q_event),
        .store_wr   (store_wr),
        .cur_param  (cur_param),
        .multi_done (multi_done)
    );

    tesp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_event (q_event),
        .head_valid (head_valid),
        .pop        (pop),
        .head_event (head_event)
    );

    tesp_back #(
        .MAX_PARAMS (MAX_PARAMS),
        .OSC_MAX    (OSC_MAX)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_event     (head_event),
        .pop            (pop),
        .store_wr       (store_wr),
        .cur_param      (cur_param),
        .multi_done     (multi_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_final_code   (m_final_code),
        .m_intermediate (m_intermediate),
        .m_item_count   (m_item_count),
        .m_item_index   (m_item_index),
        .m_param_value  (m_param_value),
        .m_osc_char     (m_osc_char),
        .m_last         (m_last)
    );

`ifndef SYNTH
    // last result of a multi-item event sits at the final index
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last && m_item_count != '0)
            |-> (COUNT_W'(m_item_index) == m_item_count - COUNT_W'(1)))
        else $error("last flag off the final index");

    // an empty event is a single transaction
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_count == '0) |-> m_last)
        else $error("empty event not marked last");

    // single events carry no items
    a_single_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EV_CONTROL || m_event_kind == EV_ESCAPE
                     || m_event_kind == EV_PRINT)) |-> (m_item_count == '0))
        else $error("single event with item count");
`endif

endmodule

// ----- src/tesp_front.sv -----
// ----------------------------------------------------------------------------
// tesp_front
// accepts characters, runs the parse state machine and collects fields
// ----------------------------------------------------------------------------
module tesp_front #(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_MAX    = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tesp_pkg::CODE_W-1:0] s_code,
    output logic                        q_push,
    input  logic                        q_ready,
    output tesp_pkg::event_t            q_event,
    output tesp_pkg::store_wr_t         store_wr,
    output logic [tesp_pkg::PVAL_W-1:0] cur_param,
    input  logic                        multi_done
);
    import tesp_pkg::*;

    localparam int PCW = $clog2(MAX_PARAMS + 1);
    localparam int OLW = $clog2(OSC_MAX + 1);

    typedef enum logic [7:0] {
        ST_GROUND     = 8'b0000_0001,
        ST_ESC        = 8'b0000_0010,
        ST_ESC_INT    = 8'b0000_0100,
        ST_CSI_ENTRY  = 8'b0000_1000,
        ST_CSI_IGNORE = 8'b0001_0000,
        ST_CSI_PARAM  = 8'b0010_0000,
        ST_CSI_INT    = 8'b0100_0000,
        ST_OSC        = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [INTER_W-1:0]  inter_reg, inter_next;
    logic [PCW-1:0]      pcnt_reg, pcnt_next;
    logic [PVAL_W-1:0]   cur_reg, cur_next;
    logic [OLW-1:0]      olen_reg, olen_next;
    logic                lock_reg, lock_next;

    logic                accept;
    logic [CODE_W-1:0]   c;
    logic                in_20_2f, in_30_7e, in_40_7e, is_digit, clear;
    logic                do_collect, do_param, push_single;
    logic [KIND_W-1:0]   single_kind;
    logic [PCW-1:0]      pc;
    logic [PVAL_W+3:0]   acc10;

    assign s_ready   = q_ready && !lock_reg;
    assign accept    = s_valid && s_ready;
    assign c         = s_code;
    assign cur_param = cur_reg;

    assign in_20_2f = (c >= 21'h20) && (c <= 21'h2f);
    assign in_30_7e = (c >= 21'h30) && (c <= 21'h7e);
    assign in_40_7e = (c >= 21'h40) && (c <= 21'h7e);
    assign is_digit = (c >= CH_ZERO) && (c <= 21'h39);
    assign pc       = (pcnt_reg == '0) ? PCW'(1) : pcnt_reg;
    assign acc10    = ({4'b0, cur_reg} << 3) + ({4'b0, cur_reg} << 1)
                      + (PVAL_W+4)'(c[3:0]);

    always_comb begin
        state_next  = state_reg;
        inter_next  = inter_reg;
        pcnt_next   = pcnt_reg;
        cur_next    = cur_reg;
        olen_next   = olen_reg;
        lock_next   = lock_reg;
        clear       = 1'b0;
        do_collect  = 1'b0;
        do_param    = 1'b0;
        push_single = 1'b0;
        single_kind = EV_CONTROL;
        q_push      = 1'b0;
        q_event     = '{kind: EV_CONTROL, code: c, inter: inter_reg, count: '0};
        store_wr    = '0;

        if (multi_done) begin
            lock_next = 1'b0;
        end

        if (accept) begin
            if (c == CH_NUL || c == CH_DEL) begin
                // ignored everywhere
            end else if (c == CH_CAN || c == CH_SUB) begin
                push_single = 1'b1;
                state_next  = ST_GROUND;
            end else if (c == CH_ESC) begin
                state_next = ST_ESC;
                clear      = 1'b1;
            end else if ((c >= 21'h01 && c <= 21'h06) || (c >= 21'h08 && c <= 21'h17)
                         || c == 21'h19 || (c >= 21'h1c && c <= 21'h1f)) begin
                push_single = 1'b1;
            end else begin
                case (state_reg)
                    ST_GROUND: begin
                        if (c >= 21'h20) begin
                            push_single = 1'b1;
                            single_kind = EV_PRINT;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_ESC: begin
                        if (c == 21'h21 || c == 21'h6b || c == 21'h50 || c == CH_OSC
                            || c == 21'h5e || c == 21'h5f) begin
                            state_next = ST_OSC;
                            clear      = 1'b1;
                        end else if (in_20_2f) begin
                            do_collect = 1'b1;
                            state_next = ST_ESC_INT;
                        end else if (c == CH_CSI) begin
                            state_next = ST_CSI_ENTRY;
                            clear      = 1'b1;
                        end else if (in_30_7e && c != 21'h58) begin
                            push_single = 1'b1;
                            single_kind = EV_ESCAPE;
                            state_next  = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_ESC_INT: begin
                        if (in_20_2f) begin
                            do_collect = 1'b1;
                        end else if (in_30_7e) begin
                            push_single = 1'b1;
                            single_kind = EV_ESCAPE;
                            state_next  = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_CSI_ENTRY: begin
                        if (in_20_2f) begin
                            do_collect = 1'b1;
                            state_next = ST_CSI_INT;
                        end else if (c == CH_COL) begin
                            state_next = ST_CSI_IGNORE;
                        end else if (is_digit || c == CH_SEMI) begin
                            do_param   = 1'b1;
                            state_next = ST_CSI_PARAM;
                        end else if (c >= 21'h3c && c <= 21'h3f) begin
                            do_collect = 1'b1;
                            state_next = ST_CSI_PARAM;
                        end else if (in_40_7e) begin
                            q_push     = 1'b1;
                            state_next = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_CSI_IGNORE: begin
                        if (c >= 21'h20 && c <= 21'h3f) begin
                            // swallowed
                        end else if (in_40_7e) begin
                            state_next = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_CSI_PARAM: begin
                        if (is_digit || c == CH_SEMI) begin
                            do_param = 1'b1;
                        end else if (c == CH_COL || (c >= 21'h3c && c <= 21'h3f)) begin
                            state_next = ST_CSI_IGNORE;
                        end else if (in_20_2f) begin
                            do_collect = 1'b1;
                            state_next = ST_CSI_INT;
                        end else if (in_40_7e) begin
                            q_push     = 1'b1;
                            state_next = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_CSI_INT: begin
                        if (in_20_2f) begin
                            do_collect = 1'b1;
                        end else if (c >= 21'h30 && c <= 21'h3f) begin
                            state_next = ST_CSI_IGNORE;
                        end else if (in_40_7e) begin
                            q_push     = 1'b1;
                            state_next = ST_GROUND;
                        end else if (c == CH_BEL) begin
                            push_single = 1'b1;
                        end
                    end
                    ST_OSC: begin
                        if (c == CH_BEL) begin
                            q_push     = 1'b1;
                            state_next = ST_GROUND;
                        end else if (c >= 21'h20 && c <= CH_DEL) begin
                            if (olen_reg < OLW'(OSC_MAX)) begin
                                store_wr.osc_we   = 1'b1;
                                store_wr.osc_addr = OSC_ADDR_W'(olen_reg);
                                store_wr.osc_data = c[OCHAR_W-1:0];
                                olen_next         = olen_reg + OLW'(1);
                            end
                        end
                    end
                    default: begin
                        state_next = ST_GROUND;
                    end
                endcase
            end

            if (q_push) begin
                lock_next = 1'b1;
                if (state_reg == ST_OSC) begin
                    q_event.kind  = EV_OSC;
                    q_event.count = COUNT_W'(olen_reg);
                end else begin
                    q_event.kind  = EV_CSI;
                    q_event.count = COUNT_W'(pcnt_reg);
                end
            end
            if (push_single) begin
                q_push       = 1'b1;
                q_event.kind = single_kind;
            end

            if (do_collect && inter_reg == '0) begin
                inter_next = c[INTER_W-1:0];
            end
            if (do_param) begin
                pcnt_next = pc;
                if (c == CH_SEMI) begin
                    if (pc < PCW'(MAX_PARAMS)) begin
                        store_wr.par_we   = 1'b1;
                        store_wr.par_addr = PAR_ADDR_W'(pc - PCW'(1));
                        store_wr.par_data = cur_reg;
                        cur_next          = '0;
                        pcnt_next         = pc + PCW'(1);
                    end
                end else if (cur_reg < PARAM_LIMIT) begin
                    cur_next = acc10[PVAL_W-1:0];
                end
            end
            if (clear) begin
                inter_next = '0;
                pcnt_next  = '0;
                cur_next   = '0;
                olen_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_GROUND;
            inter_reg <= '0;
            pcnt_reg  <= '0;
            cur_reg   <= '0;
            olen_reg  <= '0;
            lock_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            inter_reg <= inter_next;
            pcnt_reg  <= pcnt_next;
            cur_reg   <= cur_next;
            olen_reg  <= olen_next;
            lock_reg  <= lock_next;
        end
    end

endmodule

// ----- src/tesp_queue.sv -----
// ----------------------------------------------------------------------------
// tesp_queue
// short event queue between the parser front and the result sequencer
// ----------------------------------------------------------------------------
module tesp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    output logic             push_ready,
    input  tesp_pkg::event_t push_event,
    output logic             head_valid,
    input  logic             pop,
    output tesp_pkg::event_t head_event
);
    import tesp_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    event_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign push_ready = cnt_reg != CW'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_event = slot_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_event;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- src/tesp_back.sv -----
// ----------------------------------------------------------------------------
// tesp_back
// holds the parameter and osc stores and emits one result per item (one for an event without items)
// ----------------------------------------------------------------------------
module tesp_back #(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_MAX    = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  tesp_pkg::event_t             head_event,
    output logic                         pop,
    input  tesp_pkg::store_wr_t          store_wr,
    input  logic [tesp_pkg::PVAL_W-1:0]  cur_param,
    output logic                         multi_done,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tesp_pkg::KIND_W-1:0]  m_event_kind,
    output logic [tesp_pkg::CODE_W-1:0]  m_final_code,
    output logic [tesp_pkg::INTER_W-1:0] m_intermediate,
    output logic [tesp_pkg::COUNT_W-1:0] m_item_count,
    output logic [tesp_pkg::INDEX_W-1:0] m_item_index,
    output logic [tesp_pkg::PVAL_W-1:0]  m_param_value,
    output logic [tesp_pkg::OCHAR_W-1:0] m_osc_char,
    output logic                         m_last
);
    import tesp_pkg::*;

    localparam int PIW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int OIW = (OSC_MAX > 1) ? $clog2(OSC_MAX) : 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [OCHAR_W-1:0] osc_mem [OSC_MAX];
    logic [PVAL_W-1:0]  par_mem [MAX_PARAMS];
    logic [OCHAR_W-1:0] osc_q_reg;
    logic [PVAL_W-1:0]  par_q_reg;
    logic               has_items, is_last, take;

    assign has_items = head_event.count != '0;
    assign is_last   = !has_items || (COUNT_W'(idx_reg) == head_event.count - COUNT_W'(1));
    assign m_valid   = state_reg == B_OUT;
    assign take      = m_valid && m_ready;
    assign pop       = take && is_last;
    assign multi_done = pop && (head_event.kind == EV_CSI || head_event.kind == EV_OSC);

    assign m_event_kind   = head_event.kind;
    assign m_final_code   = head_event.code;
    assign m_intermediate = head_event.inter;
    assign m_item_count   = head_event.count;
    assign m_item_index   = has_items ? idx_reg : '0;
    assign m_param_value  = (has_items && head_event.kind == EV_CSI) ? par_q_reg : '0;
    assign m_osc_char     = (has_items && head_event.kind == EV_OSC) ? osc_q_reg : '0;
    assign m_last         = is_last;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            B_IDLE: begin
                if (head_valid) begin
                    idx_next   = '0;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                state_next = B_OUT;
            end
            B_OUT: begin
                if (take) begin
                    if (is_last) begin
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + INDEX_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // store writes from the front, registered reads for the sequencer
    always_ff @(posedge aclk) begin
        if (store_wr.osc_we) begin
            osc_mem[store_wr.osc_addr[OIW-1:0]] <= store_wr.osc_data;
        end
        osc_q_reg <= osc_mem[idx_reg[OIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (store_wr.par_we) begin
            par_mem[store_wr.par_addr[PIW-1:0]] <= store_wr.par_data;
        end
        if (is_last) begin
            par_q_reg <= cur_param;
        end else begin
            par_q_reg <= par_mem[idx_reg[PIW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
